@@ hdl/rotenc_pkg.sv @@
// Shared types and constants of the rotary encoder decoder.
`timescale 1ns / 1ps

package rotenc_pkg;

    localparam int unsigned POS_W  = 16;
    localparam int unsigned WIN_W  = 16;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned SRC_W  = 2;
    localparam int unsigned ADDR_W = 2;
    localparam int unsigned DATA_W = 16;

    // Event sources
    localparam logic [SRC_W-1:0] SRC_CHAN_A = 2'd0;
    localparam logic [SRC_W-1:0] SRC_SWITCH = 2'd1;

    // Configuration register indexes
    localparam logic [ADDR_W-1:0] REG_MIN_POS   = 2'd0;
    localparam logic [ADDR_W-1:0] REG_MAX_POS   = 2'd1;
    localparam logic [ADDR_W-1:0] REG_TURN_WIN  = 2'd2;
    localparam logic [ADDR_W-1:0] REG_PRESS_WIN = 2'd3;

    // Reset values
    localparam logic signed [POS_W-1:0] RST_MIN_POS   = 16'sd0;
    localparam logic signed [POS_W-1:0] RST_MAX_POS   = 16'sd180;
    localparam logic        [WIN_W-1:0] RST_TURN_WIN  = 16'd5;
    localparam logic        [WIN_W-1:0] RST_PRESS_WIN = 16'd200;
    localparam logic signed [POS_W-1:0] RST_COUNT     = 16'sd90;

    typedef struct packed {
        logic signed [POS_W-1:0] min_pos;
        logic signed [POS_W-1:0] max_pos;
        logic        [WIN_W-1:0] turn_win;
        logic        [WIN_W-1:0] press_win;
    } cfg_t;

    typedef struct packed {
        logic                    valid;
        logic signed [POS_W-1:0] value;
    } reload_t;

    typedef struct packed {
        logic [SRC_W-1:0]  source;
        logic              level_a;
        logic              level_b;
        logic              level_switch;
        logic [TIME_W-1:0] now_ms;
    } event_t;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic                    press_event;
    } result_t;

endpackage

@@ hdl/rotenc_cfg_regs.sv @@
// Configuration registers and midpoint reload of the rotary encoder decoder.
`timescale 1ns / 1ps

module rotenc_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [rotenc_pkg::ADDR_W-1:0] cfg_addr,
    input  logic [rotenc_pkg::DATA_W-1:0] cfg_wr_data,
    output rotenc_pkg::cfg_t              cfg,
    output rotenc_pkg::reload_t           reload
);

    rotenc_pkg::cfg_t cfg_reg;
    rotenc_pkg::cfg_t cfg_next;
    logic signed [rotenc_pkg::POS_W:0] sum;
    logic signed [rotenc_pkg::POS_W:0] sum_adj;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                rotenc_pkg::REG_MIN_POS:   cfg_next.min_pos   = cfg_wr_data;
                rotenc_pkg::REG_MAX_POS:   cfg_next.max_pos   = cfg_wr_data;
                rotenc_pkg::REG_TURN_WIN:  cfg_next.turn_win  = cfg_wr_data;
                rotenc_pkg::REG_PRESS_WIN: cfg_next.press_win = cfg_wr_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    // Midpoint of the new limits, truncated toward zero
    always_comb begin
        sum     = {cfg_next.min_pos[rotenc_pkg::POS_W-1], cfg_next.min_pos}
                + {cfg_next.max_pos[rotenc_pkg::POS_W-1], cfg_next.max_pos};
        sum_adj = sum + {{rotenc_pkg::POS_W{1'b0}}, sum[rotenc_pkg::POS_W]};
        reload.value = sum_adj[rotenc_pkg::POS_W:1];
        reload.valid = cfg_wr_en && ((cfg_addr == rotenc_pkg::REG_MIN_POS) ||
                                     (cfg_addr == rotenc_pkg::REG_MAX_POS));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_pos   <= rotenc_pkg::RST_MIN_POS;
            cfg_reg.max_pos   <= rotenc_pkg::RST_MAX_POS;
            cfg_reg.turn_win  <= rotenc_pkg::RST_TURN_WIN;
            cfg_reg.press_win <= rotenc_pkg::RST_PRESS_WIN;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hdl/rotenc_step.sv @@
// Decoder state and per-event step logic of the rotary encoder decoder.
`timescale 1ns / 1ps

module rotenc_step (
    input  logic                aclk,
    input  logic                aresetn,
    input  rotenc_pkg::cfg_t    cfg,
    input  rotenc_pkg::reload_t reload,
    input  logic                advance,
    input  rotenc_pkg::event_t  item,
    output rotenc_pkg::result_t result
);

    logic signed [rotenc_pkg::POS_W-1:0]  count_reg, count_next;
    logic                                 prev_a_reg, prev_a_next;
    logic        [rotenc_pkg::TIME_W-1:0] last_step_reg, last_step_next;
    logic        [rotenc_pkg::TIME_W-1:0] last_press_reg, last_press_next;

    logic        [rotenc_pkg::TIME_W-1:0] step_elapsed, press_elapsed;
    logic signed [rotenc_pkg::POS_W:0]    stepped, sat_hi, sat_lo;
    logic                                 press;

    always_comb begin
        step_elapsed  = item.now_ms - last_step_reg;
        press_elapsed = item.now_ms - last_press_reg;

        stepped = (item.level_b != item.level_a)
                ? $signed({count_reg[rotenc_pkg::POS_W-1], count_reg}) + 17'sd1
                : $signed({count_reg[rotenc_pkg::POS_W-1], count_reg}) - 17'sd1;
        // Upper limit first, then lower; compare as signed values
        sat_hi = (stepped > $signed({cfg.max_pos[rotenc_pkg::POS_W-1], cfg.max_pos}))
               ? $signed({cfg.max_pos[rotenc_pkg::POS_W-1], cfg.max_pos}) : stepped;
        sat_lo = (sat_hi < $signed({cfg.min_pos[rotenc_pkg::POS_W-1], cfg.min_pos}))
               ? $signed({cfg.min_pos[rotenc_pkg::POS_W-1], cfg.min_pos}) : sat_hi;

        count_next      = count_reg;
        prev_a_next     = prev_a_reg;
        last_step_next  = last_step_reg;
        last_press_next = last_press_reg;
        press           = 1'b0;

        if (item.source == rotenc_pkg::SRC_CHAN_A) begin
            if (step_elapsed >= {{(rotenc_pkg::TIME_W-rotenc_pkg::WIN_W){1'b0}},
                                 cfg.turn_win}) begin
                if (prev_a_reg && !item.level_a) begin
                    count_next     = sat_lo[rotenc_pkg::POS_W-1:0];
                    last_step_next = item.now_ms;
                end
                prev_a_next = item.level_a;
            end
        end else if (item.source == rotenc_pkg::SRC_SWITCH) begin
            if (press_elapsed > {{(rotenc_pkg::TIME_W-rotenc_pkg::WIN_W){1'b0}},
                                 cfg.press_win}) begin
                press           = !item.level_switch;
                last_press_next = item.now_ms;
            end
        end

        result.position    = count_next;
        result.press_event = press;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= rotenc_pkg::RST_COUNT;
            prev_a_reg     <= 1'b1;
            last_step_reg  <= '0;
            last_press_reg <= '0;
        end else if (reload.valid) begin
            count_reg <= reload.value;
        end else if (advance) begin
            count_reg      <= count_next;
            prev_a_reg     <= prev_a_next;
            last_step_reg  <= last_step_next;
            last_press_reg <= last_press_next;
        end
    end

endmodule

@@ hdl/rotary_encoder_decoder_core.sv @@
// Top level of the rotary encoder decoder: request registers, step logic, result register.
`timescale 1ns / 1ps
// An accepted request passes through the input register and then the result register to the m_ side.
// Throughput: one request per cycle while the result slot is free or drained by m_tready; the step logic
// between the two registers updates the decoder state in the same cycle it forms the result, but not on a reload.
// Reset (aresetn low, synchronous): both stages empty, limits 0 and 180, windows
// 5 ms and 200 ms, position 90, last A high, both timestamps 0.
module rotary_encoder_decoder_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input requests
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [39:0]                   s_tdata,  // level_a [0], level_b [1], level_switch [2], now_ms [34:3]
    input  logic [1:0]                    s_tuser,  // source
    // Results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,  // position
    output logic                          m_tuser,  // press_event
    // Configuration writes
    input  logic                          cfg_wr_en,
    input  logic [rotenc_pkg::ADDR_W-1:0] cfg_addr,
    input  logic [rotenc_pkg::DATA_W-1:0] cfg_wr_data
);

    rotenc_pkg::cfg_t    cfg;
    rotenc_pkg::reload_t reload;

    // Input stage
    logic                in_valid_reg;
    rotenc_pkg::event_t  in_item_reg;

    // Result stage
    logic                out_valid_reg;
    rotenc_pkg::result_t out_result_reg;

    rotenc_pkg::result_t step_result;
    logic                advance;

    // Move the held request into the result register when that slot is free
    // or being drained this cycle; the state update rides on the same edge unless a limit write reloads the position.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    // Take a new request whenever the input slot is empty or emptying.
    assign s_tready = !in_valid_reg || advance;

    rotenc_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg),
        .reload      (reload)
    );

    rotenc_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .reload  (reload),
        .advance (advance),
        .item    (in_item_reg),
        .result  (step_result)
    );

    // Control of both stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: capture the request fields, hold the result until taken
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.source       <= s_tuser;
            in_item_reg.level_a      <= s_tdata[0];
            in_item_reg.level_b      <= s_tdata[1];
            in_item_reg.level_switch <= s_tdata[2];
            in_item_reg.now_ms       <= s_tdata[34:3];
        end
        if (advance) begin
            out_result_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_result_reg.position;
    assign m_tuser  = out_result_reg.press_event;

endmodule

@@ hdl/rotenc_checker.sv @@
// Port-level checks of the rotary encoder decoder and their binding.
`timescale 1ns / 1ps

module rotenc_port_checks (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    // No result right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // An accepted request has a result on the output once it has passed the input and result registers
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> ##2 m_tvalid)
        else $error("result missing two cycles after request");

    // An empty result slot never blocks the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output empty");

endmodule

bind rotary_encoder_decoder_core rotenc_port_checks u_rotenc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
